### src/bxavg_pkg.sv
// Shared types and constants for the box-average downsampler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bxavg_pkg;

  localparam int SAMPLE_W   = 16;    // sample field on the input channel
  localparam int PIX_W      = 16;    // averaged output pixel
  localparam int ROW_W      = 12;
  localparam int COL_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_MAX    = 4096;  // largest frame dimension
  localparam int CH_MAX     = 4;     // largest channel count

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH   = 3'd0,
    REG_IN_HEIGHT  = 3'd1,
    REG_N_CHANNELS = 3'd2,
    REG_OUT_WIDTH  = 3'd3,
    REG_OUT_HEIGHT = 3'd4,
    REG_X_ZOOM     = 3'd5,
    REG_Y_ZOOM     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [12:0] in_width;
    logic [12:0] in_height;
    logic [2:0]  n_channels;
    logic [8:0]  out_width;
    logic [12:0] out_height;
    logic [4:0]  x_zoom;
    logic [4:0]  y_zoom;
  } bxavg_cfg_t;

  localparam bxavg_cfg_t CFG_RESET = '{
    in_width:   13'd64,
    in_height:  13'd64,
    n_channels: 3'd1,
    out_width:  9'd64,
    out_height: 13'd64,
    x_zoom:     5'd1,
    y_zoom:     5'd1
  };

  // Position of an output pixel, carried alongside its sum.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_done;
  } bxavg_tag_t;

  // Per-sample decode from the sequencer to the accumulator.
  typedef struct packed {
    logic       active;  // inside the cropped area, touches a column sum
    logic       first;   // first sample of its box: overwrite the sum
    logic       emit;    // last sample of its box: produce a pixel
    bxavg_tag_t tag;
  } bxavg_ctl_t;

endpackage

`default_nettype wire

### src/bxavg_if.sv
// Handshake channels of the box-average downsampler: samples in, pixels out,
// configuration writes. Depends on bxavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bxavg_sample_if;
  import bxavg_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface bxavg_pixel_if;
  import bxavg_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             frame_done;
  modport source (output valid, output out_pixel, output out_row, output out_col,
                  output frame_done, input ready);
  modport sink   (input valid, input out_pixel, input out_row, input out_col,
                  input frame_done, output ready);
endinterface

interface bxavg_cfg_if;
  import bxavg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/box_average_downsampler_top.sv
// Top level of the box-average downsampler: configuration registers, stall
// control and the three pipeline parts. Depends on bxavg_pkg, bxavg_if,
// bxavg_seq, bxavg_acc and bxavg_div.
`timescale 1ns / 1ps
`default_nettype none

// Box-average downsampler. Samples arrive in raster order (channel, then
// column, then row), one per transfer on the samples channel. Every
// y_zoom by x_zoom box of input pixels, over all channels, becomes one
// grayscale pixel on the pixels channel: the box sum divided by the box
// sample count, truncated, saturated at 65535, with its output row and
// column and a frame_done flag on the last pixel of the frame. Columns at or
// beyond out_width*x_zoom and rows at or beyond out_height*y_zoom are
// dropped. Throughput is one sample per clock, sustained, as long as the
// pixels side keeps taking transfers. After the transfer of the last sample
// of its box, a pixel passes the column sum read-modify-write stage, then the
// SUM_W stages of the bit-per-stage divider and the output register, where
// SUM_W = SAMPLE_BITS + log2(4*MAX_ZOOM^2), 26 at the defaults. A stall on
// the pixels side freezes the whole pipeline, and samples then hold off.
// After reset a sweep clears all MAX_OUT_WIDTH column sum entries (256 at
// the defaults), one entry at a time; samples are held off until it ends, while
// configuration writes are taken as usual. Registers are written through the
// cfg channel by index: 0 in_width, 1 in_height, 2 n_channels, 3 out_width,
// 4 out_height, 5 x_zoom, 6 y_zoom; other indexes are ignored. Write them
// only between frames or while no pixel is pending; they take effect at once.
module box_average_downsampler_top import bxavg_pkg::*; #(
  parameter int MAX_OUT_WIDTH = 256,
  parameter int SAMPLE_BITS   = 16,
  parameter int MAX_ZOOM      = 16
) (
  input  logic          clk,
  input  logic          rst,
  bxavg_sample_if.sink  samples,
  bxavg_pixel_if.source pixels,
  bxavg_cfg_if.sink     cfg
);

  // memory index, box sum and box divisor widths
  localparam int IDX_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_ZOOM * MAX_ZOOM * CH_MAX);
  localparam int DIV_W = $clog2(MAX_ZOOM * MAX_ZOOM * CH_MAX + 1);

  bxavg_cfg_t       cfg_q;
  bxavg_ctl_t       ctl;
  logic [IDX_W-1:0] idx;
  logic [DIV_W-1:0] divisor;

  logic             en;        // whole pipeline advances
  logic             clearing;  // memory sweep after reset
  logic             accept;    // sample transfer this cycle

  logic             div_valid;
  logic [SUM_W-1:0] div_sum;
  logic [DIV_W-1:0] div_divisor;
  bxavg_tag_t       div_tag;

  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;
  bxavg_tag_t       out_tag;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_IN_WIDTH:   cfg_q.in_width   <= cfg.data[12:0];
        REG_IN_HEIGHT:  cfg_q.in_height  <= cfg.data[12:0];
        REG_N_CHANNELS: cfg_q.n_channels <= cfg.data[2:0];
        REG_OUT_WIDTH:  cfg_q.out_width  <= cfg.data[8:0];
        REG_OUT_HEIGHT: cfg_q.out_height <= cfg.data[12:0];
        REG_X_ZOOM:     cfg_q.x_zoom     <= cfg.data[4:0];
        REG_Y_ZOOM:     cfg_q.y_zoom     <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ flow control
  // The output register decides: the pipeline moves when it is empty or
  // being drained this cycle.
  assign en            = !out_valid || pixels.ready;
  assign samples.ready = en && !clearing;
  assign accept        = samples.valid && samples.ready;

  // ---------------------------------------------------------------- datapath
  // Position counters and per-sample decode.
  bxavg_seq #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_ZOOM      (MAX_ZOOM),
    .IDX_W         (IDX_W),
    .DIV_W         (DIV_W)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .cfg     (cfg_q),
    .ctl     (ctl),
    .idx     (idx),
    .divisor (divisor)
  );

  // Column sums: read at the sample transfer into a registered stage, from which the sum is added and written back.
  bxavg_acc #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .IDX_W         (IDX_W),
    .SUM_W         (SUM_W),
    .DIV_W         (DIV_W)
  ) u_acc (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .accept      (accept),
    .ctl         (ctl),
    .idx         (idx),
    .sample      (samples.sample),
    .divisor     (divisor),
    .clearing    (clearing),
    .div_valid   (div_valid),
    .div_sum     (div_sum),
    .div_divisor (div_divisor),
    .div_tag     (div_tag)
  );

  // Closed boxes go through the divider into the output register.
  bxavg_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (div_valid),
    .in_sum     (div_sum),
    .in_divisor (div_divisor),
    .in_tag     (div_tag),
    .out_valid  (out_valid),
    .out_pixel  (out_pixel),
    .out_tag    (out_tag)
  );

  assign pixels.valid      = out_valid;
  assign pixels.out_pixel  = out_pixel;
  assign pixels.out_row    = out_tag.row;
  assign pixels.out_col    = out_tag.col;
  assign pixels.frame_done = out_tag.frame_done;

  // -------------------------------------------------------------- assertions
`ifndef SYNTHESIS
  // The clearing sweep keeps samples out right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !samples.ready)
    else $error("sample channel ready during memory clear");

  // A stalled pixel blocks new samples.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && !pixels.ready |-> !accept)
    else $error("sample taken while output stalled");

  // A new pixel only shows up right after the pipeline has moved.
  a_pixel_after_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(pixels.valid) |-> $past(en))
    else $error("pixel appeared without pipeline advance");
`endif

endmodule

`default_nettype wire

### src/bxavg_seq.sv
// Raster position sequencer: register clamping, crop test, box position
// counters and the box divisor. Depends on bxavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bxavg_seq import bxavg_pkg::*; #(
  parameter int MAX_OUT_WIDTH = 256,
  parameter int MAX_ZOOM      = 16,
  parameter int IDX_W         = 8,
  parameter int DIV_W         = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  bxavg_cfg_t       cfg,
  output bxavg_ctl_t       ctl,
  output logic [IDX_W-1:0] idx,
  output logic [DIV_W-1:0] divisor
);

  localparam int OWW = $clog2(MAX_OUT_WIDTH + 1);
  localparam int ZW  = $clog2(MAX_ZOOM + 1);
  localparam int CW  = (MAX_ZOOM > 1) ? $clog2(MAX_ZOOM) : 1;

  function automatic int clamp(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  logic [12:0]      iw_c, ih_c, oh_c;
  logic [2:0]       nc_c;
  logic [OWW-1:0]   ow_c;
  logic [ZW-1:0]    xz_c, yz_c;
  logic [OWW+ZW-1:0] col_lim;
  logic [13+ZW-1:0] row_lim;
  logic [2*ZW-1:0]  zz;
  logic [2*ZW+2:0]  div_prod;

  logic [ROW_W-1:0] in_row, in_col, orow;
  logic [1:0]       ch;
  logic [CW-1:0]    brow, bcol;
  logic [IDX_W-1:0] ocol, ocol_inc;

  logic col_on, row_on, chan_last, bcol_last, brow_last, col_end, row_end;

  assign iw_c = 13'(clamp(int'(cfg.in_width), DIM_MAX));
  assign ih_c = 13'(clamp(int'(cfg.in_height), DIM_MAX));
  assign oh_c = 13'(clamp(int'(cfg.out_height), DIM_MAX));
  assign nc_c = 3'(clamp(int'(cfg.n_channels), CH_MAX));
  assign ow_c = OWW'(clamp(int'(cfg.out_width), MAX_OUT_WIDTH));
  assign xz_c = ZW'(clamp(int'(cfg.x_zoom), MAX_ZOOM));
  assign yz_c = ZW'(clamp(int'(cfg.y_zoom), MAX_ZOOM));

  assign col_lim = ow_c * xz_c;
  assign row_lim = oh_c * yz_c;

  assign col_on    = 32'(in_col) < 32'(col_lim);
  assign row_on    = 32'(in_row) < 32'(row_lim);
  assign chan_last = ({1'b0, ch} + 3'd1) >= nc_c;
  assign bcol_last = (ZW'(bcol) + ZW'(1)) >= xz_c;
  assign brow_last = (ZW'(brow) + ZW'(1)) >= yz_c;
  assign col_end   = !((13'(in_col) + 13'd1) < iw_c);
  assign row_end   = !((13'(in_row) + 13'd1) < ih_c);
  assign ocol_inc  = (ocol == IDX_W'(MAX_OUT_WIDTH - 1)) ? '0 : ocol + IDX_W'(1);

  always_comb begin
    ctl.active         = col_on && row_on;
    ctl.first          = (brow == '0) && (bcol == '0) && (ch == 2'd0);
    ctl.emit           = col_on && row_on && chan_last && bcol_last && brow_last;
    ctl.tag.row        = orow;
    ctl.tag.col        = COL_W'(ocol);
    ctl.tag.frame_done = (32'(ocol) == 32'(ow_c) - 32'd1) &&
                         (32'(orow) == 32'(oh_c) - 32'd1);
  end

  assign idx = ocol;

  // Box area product is registered; it is only needed one stage later.
  always_ff @(posedge clk) begin
    zz <= xz_c * yz_c;
  end
  assign div_prod = zz * nc_c;
  assign divisor  = DIV_W'(div_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
      ch     <= '0;
      brow   <= '0;
      bcol   <= '0;
      orow   <= '0;
      ocol   <= '0;
    end else if (accept) begin
      if (!chan_last) begin
        ch <= ch + 2'd1;
      end else begin
        ch <= '0;
        if (!col_end) begin
          in_col <= in_col + ROW_W'(1);
          if (col_on) begin
            if (bcol_last) begin
              bcol <= '0;
              ocol <= ocol_inc;
            end else begin
              bcol <= bcol + CW'(1);
            end
          end
        end else begin
          in_col <= '0;
          bcol   <= '0;
          ocol   <= '0;
          if (!row_end) begin
            in_row <= in_row + ROW_W'(1);
            if (row_on) begin
              if (brow_last) begin
                brow <= '0;
                orow <= orow + ROW_W'(1);
              end else begin
                brow <= brow + CW'(1);
              end
            end
          end else begin
            in_row <= '0;
            brow   <= '0;
            orow   <= '0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/bxavg_acc.sv
// Column sum memory with read-modify-write, same-entry forwarding and the
// post-reset clearing sweep. Depends on bxavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bxavg_acc import bxavg_pkg::*; #(
  parameter int MAX_OUT_WIDTH = 256,
  parameter int SAMPLE_BITS   = 16,
  parameter int IDX_W         = 8,
  parameter int SUM_W         = 26,
  parameter int DIV_W         = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                accept,
  input  bxavg_ctl_t          ctl,
  input  logic [IDX_W-1:0]    idx,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [DIV_W-1:0]    divisor,
  output logic                clearing,
  output logic                div_valid,
  output logic [SUM_W-1:0]    div_sum,
  output logic [DIV_W-1:0]    div_divisor,
  output bxavg_tag_t          div_tag
);

  logic [SUM_W-1:0]       mem [MAX_OUT_WIDTH];
  logic [SUM_W-1:0]       rdata;
  logic [IDX_W-1:0]       clr_addr;

  logic                   st_valid;
  bxavg_ctl_t             st_ctl;
  logic [IDX_W-1:0]       st_idx;
  logic [SAMPLE_BITS-1:0] st_sample;
  logic                   fwd_hit;
  logic [SUM_W-1:0]       fwd_data;
  logic [SUM_W-1:0]       base, sum;

  // Read issued at the same edge that writes the previous sample back:
  // take the written value when both hit one column.
  assign base = st_ctl.first ? '0 : (fwd_hit ? fwd_data : rdata);
  assign sum  = base + SUM_W'(st_sample);

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (en && st_valid) begin
      mem[st_idx] <= sum;
    end
    if (en) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_ctl    <= ctl;
      st_idx    <= idx;
      st_sample <= SAMPLE_BITS'(sample);
      fwd_hit   <= st_valid && (st_idx == idx);
      fwd_data  <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      clearing <= 1'b1;
      clr_addr <= '0;
    end else begin
      if (en) begin
        st_valid <= accept && ctl.active;
      end
      if (clearing) begin
        if (clr_addr == IDX_W'(MAX_OUT_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + IDX_W'(1);
      end
    end
  end

  assign div_valid   = st_valid && st_ctl.emit;
  assign div_sum     = sum;
  assign div_divisor = divisor;
  assign div_tag     = st_ctl.tag;

endmodule

`default_nettype wire

### src/bxavg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation
// to the pixel width and the output register. Depends on bxavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bxavg_div import bxavg_pkg::*; #(
  parameter int SUM_W = 26,
  parameter int DIV_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SUM_W-1:0] in_sum,
  input  logic [DIV_W-1:0] in_divisor,
  input  bxavg_tag_t       in_tag,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_pixel,
  output bxavg_tag_t       out_tag
);

  // s_* feed stage k, n_* are its results, r_* its registers
  logic             s_val [SUM_W];
  logic [DIV_W-1:0] s_rem [SUM_W];
  logic [SUM_W-1:0] s_num [SUM_W];
  logic [SUM_W-1:0] s_quo [SUM_W];
  logic [DIV_W-1:0] s_div [SUM_W];
  bxavg_tag_t       s_tag [SUM_W];

  logic [DIV_W-1:0] n_rem [SUM_W];
  logic [SUM_W-1:0] n_quo [SUM_W];

  logic             r_val [SUM_W];
  logic [DIV_W-1:0] r_rem [SUM_W];
  logic [SUM_W-1:0] r_num [SUM_W];
  logic [SUM_W-1:0] r_quo [SUM_W];
  logic [DIV_W-1:0] r_div [SUM_W];
  bxavg_tag_t       r_tag [SUM_W];

  logic [SUM_W-1:0] q_last;
  logic             sat;

  always_comb begin
    s_val[0] = in_valid;
    s_rem[0] = '0;
    s_num[0] = in_sum;
    s_quo[0] = '0;
    s_div[0] = in_divisor;
    s_tag[0] = in_tag;
    for (int k = 1; k < SUM_W; k++) begin
      s_val[k] = r_val[k-1];
      s_rem[k] = r_rem[k-1];
      s_num[k] = r_num[k-1];
      s_quo[k] = r_quo[k-1];
      s_div[k] = r_div[k-1];
      s_tag[k] = r_tag[k-1];
    end
  end

  always_comb begin
    logic [DIV_W:0] trial;
    logic           ge;
    for (int k = 0; k < SUM_W; k++) begin
      trial    = {s_rem[k], s_num[k][SUM_W-1]};
      ge       = trial >= {1'b0, s_div[k]};
      n_rem[k] = ge ? DIV_W'(trial - {1'b0, s_div[k]}) : DIV_W'(trial);
      n_quo[k] = {s_quo[k][SUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SUM_W; k++) begin
        r_rem[k] <= n_rem[k];
        r_num[k] <= s_num[k] << 1;
        r_quo[k] <= n_quo[k];
        r_div[k] <= s_div[k];
        r_tag[k] <= s_tag[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SUM_W; k++) begin
        r_val[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < SUM_W; k++) begin
        r_val[k] <= s_val[k];
      end
      out_valid <= r_val[SUM_W-1];
    end
  end

  assign q_last = r_quo[SUM_W-1];
  assign sat    = (q_last >> PIX_W) != '0;

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel <= sat ? '1 : PIX_W'(q_last);
      out_tag   <= r_tag[SUM_W-1];
    end
  end

endmodule

`default_nettype wire

### tb/tb_box_average_downsampler_top.sv
// Self-checking bench for box_average_downsampler_top: a scoreboard class predicts
// each box average from the accepted samples, and plain tasks drive the three channels.
// Depends on bxavg_pkg, bxavg_if and the RTL of the downsampler.
`timescale 1ns / 1ps

module tb_box_average_downsampler_top import bxavg_pkg::*;;

  localparam int MAX_OUT_W    = 256;      // column sum store depth
  localparam int MAX_ZOOM_C   = 16;
  localparam int DRAIN_CYCLES = 40;       // idle wait that covers the pipeline depth
  localparam int RANDOM_ITEMS = 1900;     // in-box samples in the random part
  localparam int QUIET_ITEMS  = 300;      // tail of the run with no idling
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // index with no register

  typedef enum int {FILL_RANDOM, FILL_EXTREMES, FILL_MAX} fill_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } pixel_t;

  // Predicts box averages and holds the pixels still due from the block.
  class bxavg_scoreboard;
    bxavg_cfg_t  regs;
    logic [31:0] col_sum [MAX_OUT_W];
    logic [11:0] in_row, in_col, out_row;
    logic [7:0]  out_col;
    logic [1:0]  chan;
    logic [3:0]  box_row, box_col;
    pixel_t      pixel_due_q[$];
    int          errors, checked, taken;

    function new();
      regs = CFG_RESET;
      foreach (col_sum[i]) col_sum[i] = '0;
      in_row = '0; in_col = '0; out_row = '0; out_col = '0;
      chan = '0; box_row = '0; box_col = '0;
      errors = 0; checked = 0; taken = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IN_WIDTH:   regs.in_width   = data;
        REG_IN_HEIGHT:  regs.in_height  = data;
        REG_N_CHANNELS: regs.n_channels = data[2:0];
        REG_OUT_WIDTH:  regs.out_width  = data[8:0];
        REG_OUT_HEIGHT: regs.out_height = data;
        REG_X_ZOOM:     regs.x_zoom     = data[4:0];
        REG_Y_ZOOM:     regs.y_zoom     = data[4:0];
        default: ;
      endcase
    endfunction

    function int clamp(int v, int hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Adds one sample to its column sum; returns 1 when it lies inside the crop.
    function bit note_sample(logic [SAMPLE_W-1:0] s);
      int          iw, ih, nc, ow, oh, xz, yz;
      bit          col_on, row_on;
      logic [31:0] sum, avg;
      pixel_t      px;
      iw = clamp(int'(regs.in_width), DIM_MAX);
      ih = clamp(int'(regs.in_height), DIM_MAX);
      nc = clamp(int'(regs.n_channels), CH_MAX);
      ow = clamp(int'(regs.out_width), MAX_OUT_W);
      oh = clamp(int'(regs.out_height), DIM_MAX);
      xz = clamp(int'(regs.x_zoom), MAX_ZOOM_C);
      yz = clamp(int'(regs.y_zoom), MAX_ZOOM_C);
      col_on = int'(in_col) < ow * xz;
      row_on = int'(in_row) < oh * yz;
      taken++;
      if (col_on && row_on) begin
        // first sample of a box overwrites the stale sum
        sum = ((box_row == 0 && box_col == 0 && chan == 0) ? 32'd0 : col_sum[out_col])
              + 32'(s);
        col_sum[out_col] = sum;
        if (int'(chan) + 1 >= nc && int'(box_col) + 1 >= xz && int'(box_row) + 1 >= yz) begin
          avg      = sum / 32'(xz * yz * nc);
          px.pixel = (avg > 32'hFFFF) ? 16'hFFFF : avg[15:0];
          px.row   = out_row;
          px.col   = out_col;
          px.done  = (int'(out_col) == ow - 1) && (int'(out_row) == oh - 1);
          pixel_due_q.push_back(px);
        end
      end
      if (int'(chan) + 1 < nc) begin
        chan++;
      end else begin
        chan = '0;
        if (col_on) begin
          if (int'(box_col) + 1 >= xz) begin
            box_col = '0;
            out_col++;
          end else begin
            box_col++;
          end
        end
        if (int'(in_col) + 1 < iw) begin
          in_col++;
        end else begin
          in_col = '0; box_col = '0; out_col = '0;
          if (row_on) begin
            if (int'(box_row) + 1 >= yz) begin
              box_row = '0;
              out_row++;
            end else begin
              box_row++;
            end
          end
          if (int'(in_row) + 1 < ih) begin
            in_row++;
          end else begin
            in_row = '0; box_row = '0; out_row = '0;
          end
        end
      end
      return col_on && row_on;
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pixel_due_q.size() == 0) begin
        errors++;
        $display("%0t: pixel with none due: pixel %0d row %0d col %0d done %0d",
                 $time, got.pixel, got.row, got.col, got.done);
        return;
      end
      want = pixel_due_q.pop_front();
      checked++;
      compare_field("out_pixel", want.pixel, got.pixel);
      compare_field("out_row", want.row, got.row);
      compare_field("out_col", want.col, got.col);
      compare_field("frame_done", want.done, got.done);
    endfunction

    function int pending();
      return pixel_due_q.size();
    endfunction

    function bit at_frame_start();
      return in_row == 0 && in_col == 0 && chan == 0;
    endfunction
  endclass

  logic clk;
  logic rst;

  bxavg_sample_if sample_bus();
  bxavg_pixel_if  pixel_bus();
  bxavg_cfg_if    cfg_bus();

  box_average_downsampler_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .pixels  (pixel_bus),
    .cfg     (cfg_bus)
  );

  bxavg_scoreboard sb;
  pixel_t          seen_px;
  int              src_gap_pct    = 10;  // chance of a sender gap before a sample
  int              sink_stall_pct = 10;  // chance per cycle of a pixel-side stall
  bit              quiet          = 1'b0;
  int              n_active       = 0;
  int              n_setups       = 0;
  int              cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing pixel ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d pixels still due", $time, sb.pending());
      $display("tb_box_average_downsampler_top NOT OK");
      $finish;
    end
  end

  // Pixel side: random stall bursts, none in the quiet tail.
  initial begin
    pixel_bus.ready <= 1'b1;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
        pixel_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      pixel_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Every pixel transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && pixel_bus.valid && pixel_bus.ready) begin
      seen_px.pixel = pixel_bus.out_pixel;
      seen_px.row   = pixel_bus.out_row;
      seen_px.col   = pixel_bus.out_col;
      seen_px.done  = pixel_bus.frame_done;
      sb.check_pixel(seen_px);
    end
  end

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 20;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(fill_t fill);
    case (fill)
      FILL_RANDOM: return 16'($urandom);
      FILL_EXTREMES: begin
        case ($urandom_range(0, 3))
          0:       return 16'h0000;
          1:       return 16'hFFFF;
          default: return 16'($urandom);
        endcase
      end
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic bxavg_cfg_t make_setup(int iw, int ih, int nc, int ow, int oh,
                                            int xz, int yz);
    bxavg_cfg_t c;
    c.in_width   = 13'(iw);
    c.in_height  = 13'(ih);
    c.n_channels = 3'(nc);
    c.out_width  = 9'(ow);
    c.out_height = 13'(oh);
    c.x_zoom     = 5'(xz);
    c.y_zoom     = 5'(yz);
    return c;
  endfunction

  // One sample transfer. valid is lowered only when a gap starts, so back-to-back
  // samples keep it high with a single assignment per edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (!quiet && $urandom_range(0, 99) < src_gap_pct) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    if (sb.note_sample(s)) n_active++;
  endtask

  // One register transfer; the caller drops valid after the last one.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.apply_reg(idx, data);
  endtask

  // Registers change only with the block idle: every due pixel out, then a
  // drain for samples that are still in the pipe without a pixel behind them.
  task automatic load_setup(input bxavg_cfg_t c, input bit poke_unused);
    sample_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(REG_IN_WIDTH, c.in_width);
    cfg_write(REG_IN_HEIGHT, c.in_height);
    cfg_write(REG_N_CHANNELS, 13'(c.n_channels));
    cfg_write(REG_OUT_WIDTH, 13'(c.out_width));
    cfg_write(REG_OUT_HEIGHT, c.out_height);
    cfg_write(REG_X_ZOOM, 13'(c.x_zoom));
    cfg_write(REG_Y_ZOOM, 13'(c.y_zoom));
    if (poke_unused) cfg_write(REG_UNUSED, 13'($urandom));
    cfg_bus.valid <= 1'b0;
    n_setups++;
  endtask

  initial begin : stimulus
    bxavg_cfg_t setup;
    int         kind, xz, yz, ow, oh, nc, frame_len, count;
    fill_t      fill;

    sb = new();
    rst               <= 1'b1;
    sample_bus.valid  <= 1'b0;
    sample_bus.sample <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= '0;
    cfg_bus.data      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset setup: 1x1 boxes of one channel, so each sample is a pixel.
    // The first transfer also waits out the column sum clear.
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h0001);

    // All registers zero read as 1, plus a write to the unused index.
    // The counters sit on column 4, so the first sample falls outside the crop.
    load_setup('0, 1'b1);
    repeat (3) send_sample(pick_sample(FILL_RANDOM));

    // Box of two rows cut to one row mid-box: the sum holds two rows of
    // full-scale samples over a one-row divisor, so the average saturates.
    load_setup(make_setup(1, 2, 1, 1, 2, 1, 2), 1'b0);
    send_sample(16'hFFFF);
    load_setup(make_setup(1, 2, 1, 1, 2, 1, 1), 1'b0);
    send_sample(16'hFFFF);

    // Largest box: 16x16 pixels of 4 channels at full scale, the widest sum.
    load_setup(make_setup(16, 16, CH_MAX, 1, 1, MAX_ZOOM_C, MAX_ZOOM_C), 1'b0);
    repeat (16 * 16 * CH_MAX) send_sample(16'hFFFF);

    // Widest output row: column counter wraps, trailing columns dropped.
    load_setup(make_setup(MAX_OUT_W + 4, 1, 1, MAX_OUT_W, 1, 1, 1), 1'b0);
    repeat (MAX_OUT_W + 4) send_sample(pick_sample(FILL_RANDOM));

    // Every register above its range reads as its maximum.
    load_setup(make_setup(8191, 8191, 7, 511, 8191, 31, 31), 1'b1);
    repeat (4) send_sample(pick_sample(FILL_EXTREMES));

    // Random phases. Most are consistent setups fed whole frames of random
    // content after the counters are walked back to the frame start; some cut
    // a frame short, and some write arbitrary register values and feed noise.
    n_active = 0;
    while (n_active < RANDOM_ITEMS) begin
      quiet          = (n_active >= RANDOM_ITEMS - QUIET_ITEMS);
      src_gap_pct    = pick_gap_pct();
      sink_stall_pct = pick_gap_pct();
      kind           = $urandom_range(0, 9);
      if (kind < 8) begin
        xz = ($urandom_range(0, 7) == 0) ? $urandom_range(4, MAX_ZOOM_C) : $urandom_range(1, 3);
        yz = ($urandom_range(0, 7) == 0) ? $urandom_range(4, MAX_ZOOM_C) : $urandom_range(1, 3);
        ow = (xz > 3) ? 1 : $urandom_range(1, 4);
        oh = (yz > 3) ? 1 : $urandom_range(1, 3);
        nc = (xz * yz > 16) ? $urandom_range(1, 2) : $urandom_range(1, CH_MAX);
        setup = make_setup(ow * xz + $urandom_range(0, 2), oh * yz + $urandom_range(0, 2),
                           nc, ow, oh, xz, yz);
        load_setup(setup, $urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) == 0)
          fill = FILL_MAX;
        else
          fill = ($urandom_range(0, 2) == 0) ? FILL_EXTREMES : FILL_RANDOM;
        while (!sb.at_frame_start()) send_sample(pick_sample(fill));
        frame_len = int'(setup.in_width) * int'(setup.in_height) * nc;
        count = (frame_len > 200) ? frame_len : frame_len * $urandom_range(1, 3);
        // broken frame: stop somewhere inside it
        if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
        repeat (count) send_sample(pick_sample(fill));
      end else begin
        setup.in_width   = 13'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 8191));
        setup.in_height  = 13'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 8191));
        setup.n_channels = 3'($urandom_range(0, 7));
        setup.out_width  = 9'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 511));
        setup.out_height = 13'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 8191));
        setup.x_zoom     = 5'($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 31));
        setup.y_zoom     = 5'($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 31));
        load_setup(setup, 1'b1);
        repeat ($urandom_range(10, 60)) send_sample(pick_sample(FILL_RANDOM));
      end
    end

    // Drain: all due pixels, then the pipeline depth for anything stray.
    sample_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d samples sent, %0d pixels compared, %0d register setups applied",
             sb.taken, sb.checked, n_setups);
    $display("zooms 1..16, 1..4 channels, clamped and unused registers, cropping, saturation");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_box_average_downsampler_top OK");
    else
      $display("tb_box_average_downsampler_top NOT OK");
    $finish;
  end

endmodule

### sim.f
src/bxavg_pkg.sv
src/bxavg_if.sv
src/bxavg_seq.sv
src/bxavg_acc.sv
src/bxavg_div.sv
src/box_average_downsampler_top.sv
tb/tb_box_average_downsampler_top.sv
